// File: hw/rtl/fac_pkg.sv
// Shared types and constants for the frustum box culling block.
package fac_pkg;

   localparam logic [1:0] MODE_LOAD_VIEW = 2'd0;
   localparam logic [1:0] MODE_LOAD_PROJ = 2'd1;
   localparam logic [1:0] MODE_TEST_BOX  = 2'd2;

   localparam int ELEM_W      = 16;
   localparam int COORD_W     = 24;
   localparam int COEF_W      = 35;
   localparam int ACC_W       = 34;
   localparam int PLANE_COUNT = 6;
   localparam int PLANE_AW    = 3;
   localparam int PLANE_W     = 4 * COEF_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BUILD,
      ST_TEST,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic                en;
      logic [PLANE_AW-1:0] addr;
      logic [PLANE_W-1:0]  data;
   } plane_wr_type;

endpackage

// File: hw/rtl/frustum_aabb_cull.sv
// Top level of the frustum box culling block.
//
// One input channel (req_) carries either a matrix element load or a box
// test; the result channel (rsp_) carries one visibility flag per box test.
// A load beat writes the element into the view or projection memory, then
// the block rebuilds the six planes: 64 multiply-accumulate steps through one
// 16 by 16 multiplier plus 6 plane writes; the next beat is taken only after
// the last plane write. Loads and unused mode codes give no result.
// A box test reads one plane a cycle from the plane memory and evaluates the
// most positive corner with three multipliers; the next beat is taken once
// the result has moved into the output register.
// The result sits in an output register; a new beat is taken while it waits,
// and a later result waits until the receiver takes the earlier one.
// After reset both matrices and all planes read as zero, so every box is
// reported visible until the matrices are loaded.
module frustum_aabb_cull (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_mode,
   input  logic [3:0]                        req_element_index,
   input  logic signed [fac_pkg::ELEM_W-1:0]  req_element_value,
   input  logic signed [fac_pkg::COORD_W-1:0] req_box_min_x,
   input  logic signed [fac_pkg::COORD_W-1:0] req_box_min_y,
   input  logic signed [fac_pkg::COORD_W-1:0] req_box_min_z,
   input  logic signed [fac_pkg::COORD_W-1:0] req_box_max_x,
   input  logic signed [fac_pkg::COORD_W-1:0] req_box_max_y,
   input  logic signed [fac_pkg::COORD_W-1:0] req_box_max_z,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_box_visible
);

   fac_pkg::state_type state_ff, state_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_vis_ff, rsp_vis_in;
   logic culled_ff, culled_in;
   logic [fac_pkg::PLANE_COUNT-1:0] plane_vld_ff, plane_vld_in;

   logic accept, load_en, test_start, build_done, test_done, test_culled;
   logic slot_free;
   fac_pkg::plane_wr_type        plane_wr;
   logic [fac_pkg::PLANE_AW-1:0] plane_raddr;
   logic [fac_pkg::PLANE_W-1:0]  plane_rdata;

   assign accept     = req_valid && req_ready;
   assign load_en    = accept && (req_mode == fac_pkg::MODE_LOAD_VIEW
                                  || req_mode == fac_pkg::MODE_LOAD_PROJ);
   assign test_start = accept && (req_mode == fac_pkg::MODE_TEST_BOX);
   assign slot_free  = !rsp_valid_ff || rsp_ready;

   fac_plane_build u_build (
      .clock      (clock),
      .reset      (reset),
      .load_en    (load_en),
      .load_proj  (req_mode == fac_pkg::MODE_LOAD_PROJ),
      .load_index (req_element_index),
      .load_value (req_element_value),
      .start      (load_en),
      .plane_wr   (plane_wr),
      .done       (build_done)
   );

   fac_ram #(.WIDTH(fac_pkg::PLANE_W), .DEPTH(fac_pkg::PLANE_COUNT)) u_plane_ram (
      .clock (clock),
      .we    (plane_wr.en),
      .waddr (plane_wr.addr),
      .wdata (plane_wr.data),
      .raddr (plane_raddr),
      .rdata (plane_rdata)
   );

   fac_box_test u_test (
      .clock       (clock),
      .reset       (reset),
      .start       (test_start),
      .min_x       (req_box_min_x),
      .min_y       (req_box_min_y),
      .min_z       (req_box_min_z),
      .max_x       (req_box_max_x),
      .max_y       (req_box_max_y),
      .max_z       (req_box_max_z),
      .plane_vld   (plane_vld_ff),
      .plane_rdata (plane_rdata),
      .plane_raddr (plane_raddr),
      .done        (test_done),
      .culled      (test_culled)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fac_pkg::ST_IDLE: begin
            if (load_en) begin
               state_in = fac_pkg::ST_BUILD;
            end else if (test_start) begin
               state_in = fac_pkg::ST_TEST;
            end
         end
         fac_pkg::ST_BUILD: begin
            if (build_done) begin
               state_in = fac_pkg::ST_IDLE;
            end
         end
         fac_pkg::ST_TEST: begin
            if (test_done) begin
               state_in = fac_pkg::ST_RESULT;
            end
         end
         fac_pkg::ST_RESULT: begin
            if (slot_free) begin
               state_in = fac_pkg::ST_IDLE;
            end
         end
         default: state_in = fac_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = (state_ff == fac_pkg::ST_IDLE);
      culled_in    = culled_ff;
      rsp_vis_in   = rsp_vis_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      plane_vld_in = plane_vld_ff;
      if (plane_wr.en) begin
         plane_vld_in[plane_wr.addr] = 1'b1;
      end
      if (state_ff == fac_pkg::ST_TEST && test_done) begin
         culled_in = test_culled;
      end
      if (state_ff == fac_pkg::ST_RESULT && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_vis_in   = !culled_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fac_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         plane_vld_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         plane_vld_ff <= plane_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      culled_ff  <= culled_in;
      rsp_vis_ff <= rsp_vis_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_box_visible = rsp_vis_ff;

endmodule

// File: hw/rtl/fac_ram.sv
// Generic single write port memory with a registered read port.
module fac_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hw/rtl/fac_plane_build.sv
// Matrix storage and the sequencer that rebuilds the six clip planes.
module fac_plane_build (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load_en,
   input  logic                       load_proj,
   input  logic [3:0]                 load_index,
   input  logic [fac_pkg::ELEM_W-1:0] load_value,
   input  logic                       start,
   output fac_pkg::plane_wr_type      plane_wr,
   output logic                       done
);

   logic [15:0] view_vld_ff, view_vld_in;
   logic [15:0] proj_vld_ff, proj_vld_in;
   logic        iss_act_ff, iss_act_in;
   logic [5:0]  iss_cnt_ff, iss_cnt_in;
   logic        s1_vld_ff;
   logic [5:0]  s1_cnt_ff;
   logic        s1_vmask_ff, s1_pmask_ff;
   logic        s2_vld_ff;
   logic [5:0]  s2_cnt_ff;
   logic signed [2*fac_pkg::ELEM_W-1:0] s2_prod_ff;
   logic signed [fac_pkg::ACC_W-1:0]    acc_ff [16];
   logic        wr_act_ff, wr_act_in;
   logic [fac_pkg::PLANE_AW-1:0] wr_p_ff, wr_p_in;

   logic [3:0]                 view_raddr, proj_raddr;
   logic [fac_pkg::ELEM_W-1:0] view_rdata, proj_rdata;
   logic signed [fac_pkg::ELEM_W-1:0] view_op, proj_op;

   assign view_raddr = {iss_cnt_ff[5:4], iss_cnt_ff[1:0]};
   assign proj_raddr = {iss_cnt_ff[1:0], iss_cnt_ff[3:2]};

   fac_ram #(.WIDTH(fac_pkg::ELEM_W), .DEPTH(16)) u_view_ram (
      .clock (clock),
      .we    (load_en && !load_proj),
      .waddr (load_index),
      .wdata (load_value),
      .raddr (view_raddr),
      .rdata (view_rdata)
   );

   fac_ram #(.WIDTH(fac_pkg::ELEM_W), .DEPTH(16)) u_proj_ram (
      .clock (clock),
      .we    (load_en && load_proj),
      .waddr (load_index),
      .wdata (load_value),
      .raddr (proj_raddr),
      .rdata (proj_rdata)
   );

   assign view_op = s1_vmask_ff ? $signed(view_rdata) : '0;
   assign proj_op = s1_pmask_ff ? $signed(proj_rdata) : '0;

   always_comb begin
      view_vld_in = view_vld_ff;
      proj_vld_in = proj_vld_ff;
      if (load_en && !load_proj) begin
         view_vld_in[load_index] = 1'b1;
      end
      if (load_en && load_proj) begin
         proj_vld_in[load_index] = 1'b1;
      end
      iss_act_in = iss_act_ff;
      iss_cnt_in = iss_cnt_ff;
      if (start) begin
         iss_act_in = 1'b1;
         iss_cnt_in = '0;
      end else if (iss_act_ff) begin
         iss_cnt_in = iss_cnt_ff + 6'd1;
         if (iss_cnt_ff == 6'd63) begin
            iss_act_in = 1'b0;
         end
      end
      wr_act_in = wr_act_ff;
      wr_p_in   = wr_p_ff;
      if (s2_vld_ff && s2_cnt_ff == 6'd63) begin
         wr_act_in = 1'b1;
         wr_p_in   = '0;
      end else if (wr_act_ff) begin
         wr_p_in = wr_p_ff + 3'd1;
         if (wr_p_ff == 3'(fac_pkg::PLANE_COUNT - 1)) begin
            wr_act_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         view_vld_ff <= '0;
         proj_vld_ff <= '0;
         iss_act_ff  <= 1'b0;
         iss_cnt_ff  <= '0;
         s1_vld_ff   <= 1'b0;
         s2_vld_ff   <= 1'b0;
         wr_act_ff   <= 1'b0;
         wr_p_ff     <= '0;
      end else begin
         view_vld_ff <= view_vld_in;
         proj_vld_ff <= proj_vld_in;
         iss_act_ff  <= iss_act_in;
         iss_cnt_ff  <= iss_cnt_in;
         s1_vld_ff   <= iss_act_ff;
         s2_vld_ff   <= s1_vld_ff;
         wr_act_ff   <= wr_act_in;
         wr_p_ff     <= wr_p_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_cnt_ff   <= iss_cnt_ff;
      s1_vmask_ff <= view_vld_ff[view_raddr];
      s1_pmask_ff <= proj_vld_ff[proj_raddr];
      s2_cnt_ff   <= s1_cnt_ff;
      s2_prod_ff  <= view_op * proj_op;
      if (s2_vld_ff) begin
         if (s2_cnt_ff[1:0] == 2'd0) begin
            acc_ff[s2_cnt_ff[5:2]] <= fac_pkg::ACC_W'(s2_prod_ff);
         end else begin
            acc_ff[s2_cnt_ff[5:2]] <= acc_ff[s2_cnt_ff[5:2]]
                                      + fac_pkg::ACC_W'(s2_prod_ff);
         end
      end
   end

   always_comb begin
      logic signed [fac_pkg::COEF_W-1:0] base;
      logic signed [fac_pkg::COEF_W-1:0] other;
      plane_wr.en   = wr_act_ff;
      plane_wr.addr = wr_p_ff;
      plane_wr.data = '0;
      for (int r = 0; r < 4; r++) begin
         base  = fac_pkg::COEF_W'(acc_ff[4 * r + 3]);
         other = fac_pkg::COEF_W'(acc_ff[{2'(r), wr_p_ff[2:1]}]);
         plane_wr.data[fac_pkg::COEF_W * r +: fac_pkg::COEF_W] =
            wr_p_ff[0] ? base - other : base + other;
      end
   end

   assign done = wr_act_ff && (wr_p_ff == 3'(fac_pkg::PLANE_COUNT - 1));

endmodule

// File: hw/rtl/fac_box_test.sv
// Plane by plane test of a box against the stored clip planes.
module fac_box_test (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [fac_pkg::COORD_W-1:0] min_x,
   input  logic signed [fac_pkg::COORD_W-1:0] min_y,
   input  logic signed [fac_pkg::COORD_W-1:0] min_z,
   input  logic signed [fac_pkg::COORD_W-1:0] max_x,
   input  logic signed [fac_pkg::COORD_W-1:0] max_y,
   input  logic signed [fac_pkg::COORD_W-1:0] max_z,
   input  logic [fac_pkg::PLANE_COUNT-1:0]   plane_vld,
   input  logic [fac_pkg::PLANE_W-1:0]       plane_rdata,
   output logic [fac_pkg::PLANE_AW-1:0]      plane_raddr,
   output logic                              done,
   output logic                              culled
);

   localparam int PROD_W = fac_pkg::COEF_W + fac_pkg::COORD_W;
   localparam int SUM_W  = PROD_W + 3;

   logic signed [fac_pkg::COORD_W-1:0] lo_ff [3];
   logic signed [fac_pkg::COORD_W-1:0] hi_ff [3];
   logic        iss_act_ff, iss_act_in;
   logic [fac_pkg::PLANE_AW-1:0] iss_p_ff, iss_p_in;
   logic        s1_vld_ff, s1_last_ff, s1_mask_ff;
   logic        s2_vld_ff, s2_last_ff, s2_nz_ff;
   logic signed [PROD_W-1:0]         s2_prod_ff [3];
   logic signed [fac_pkg::COEF_W-1:0] s2_d_ff;
   logic        cull_ff, cull_in;

   logic signed [fac_pkg::COEF_W-1:0] coef [4];
   logic signed [SUM_W-1:0]           sum;
   logic                              plane_cull;

   assign plane_raddr = iss_p_ff;

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         coef[r] = s1_mask_ff ? $signed(plane_rdata[fac_pkg::COEF_W * r +: fac_pkg::COEF_W])
                              : '0;
      end
   end

   always_comb begin
      iss_act_in = iss_act_ff;
      iss_p_in   = iss_p_ff;
      if (start) begin
         iss_act_in = 1'b1;
         iss_p_in   = '0;
      end else if (iss_act_ff) begin
         iss_p_in = iss_p_ff + 3'd1;
         if (iss_p_ff == 3'(fac_pkg::PLANE_COUNT - 1)) begin
            iss_act_in = 1'b0;
         end
      end
   end

   assign sum = SUM_W'(s2_prod_ff[0]) + SUM_W'(s2_prod_ff[1]) + SUM_W'(s2_prod_ff[2])
                + SUM_W'($signed({s2_d_ff, 8'd0}));
   assign plane_cull = s2_vld_ff && s2_nz_ff && (sum <= 0);

   always_comb begin
      cull_in = cull_ff;
      if (start) begin
         cull_in = 1'b0;
      end else if (plane_cull) begin
         cull_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iss_act_ff <= 1'b0;
         iss_p_ff   <= '0;
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         cull_ff    <= 1'b0;
      end else begin
         iss_act_ff <= iss_act_in;
         iss_p_ff   <= iss_p_in;
         s1_vld_ff  <= iss_act_ff;
         s2_vld_ff  <= s1_vld_ff;
         cull_ff    <= cull_in;
      end
   end

   // The corner that maximises the plane value takes the larger bound for a
   // non-negative coefficient and the smaller one otherwise, even when the
   // stated minimum lies above the maximum.
   always_ff @(posedge clock) begin
      if (start) begin
         lo_ff[0] <= min_x;
         lo_ff[1] <= min_y;
         lo_ff[2] <= min_z;
         hi_ff[0] <= max_x;
         hi_ff[1] <= max_y;
         hi_ff[2] <= max_z;
      end
      s1_last_ff <= iss_p_ff == 3'(fac_pkg::PLANE_COUNT - 1);
      s1_mask_ff <= plane_vld[iss_p_ff];
      s2_last_ff <= s1_last_ff;
      s2_nz_ff   <= (coef[0] != 0) || (coef[1] != 0) || (coef[2] != 0);
      s2_d_ff    <= coef[3];
      for (int i = 0; i < 3; i++) begin
         s2_prod_ff[i] <= coef[i] * ((coef[i][fac_pkg::COEF_W-1] ^ (lo_ff[i] > hi_ff[i]))
                                     ? lo_ff[i] : hi_ff[i]);
      end
   end

   assign done   = s2_vld_ff && s2_last_ff;
   assign culled = cull_ff || plane_cull;

endmodule
